// File: rtl/tec_pkg.sv
// ----------------------------------------------------------------------------
// Text encoding classifier package
// Result codes, byte range limits and the per-string validator state type.
// ----------------------------------------------------------------------------
package tec_pkg;

	typedef enum logic [1:0] {
		VERDICT_INVALID = 2'd0,
		VERDICT_ASCII   = 2'd1,
		VERDICT_VALID   = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		CLASS_EMPTY = 3'd0,
		CLASS_ASCII = 3'd1,
		CLASS_UTF8  = 3'd2,
		CLASS_GBK   = 3'd3,
		CLASS_SJIS  = 3'd4,
		CLASS_OTHER = 3'd5
	} class_t;

	localparam logic [7:0] BYTE_HIGH      = 8'h80;
	localparam logic [7:0] UTF8_LEAD_2    = 8'hC0;
	localparam logic [7:0] UTF8_LEAD_3    = 8'hE0;
	localparam logic [7:0] UTF8_LEAD_4    = 8'hF0;
	localparam logic [7:0] UTF8_LEAD_5    = 8'hF8;
	localparam logic [7:0] UTF8_LEAD_6    = 8'hFC;
	localparam logic [7:0] UTF8_LEAD_BAD  = 8'hFE;
	localparam logic [7:0] MB_LEAD_LO     = 8'h81;
	localparam logic [7:0] GBK_LEAD_HI    = 8'hFE;
	localparam logic [7:0] TRAIL_LO       = 8'h40;
	localparam logic [7:0] GBK_TRAIL_HI   = 8'hFE;
	localparam logic [7:0] SJIS_LEAD1_HI  = 8'h9F;
	localparam logic [7:0] SJIS_KANA_LO   = 8'hA1;
	localparam logic [7:0] SJIS_KANA_HI   = 8'hDF;
	localparam logic [7:0] SJIS_LEAD2_LO  = 8'hE0;
	localparam logic [7:0] SJIS_LEAD2_HI  = 8'hEF;
	localparam logic [7:0] SJIS_TRAIL_HI  = 8'hFC;
	localparam logic [7:0] SJIS_TRAIL_BAD = 8'h7F;

	typedef struct packed {
		logic [2:0] utf8_remaining;
		logic       utf8_failed;
		logic       gbk_pending;
		logic       gbk_failed;
		logic       sjis_pending;
		logic       sjis_failed;
		logic       high_seen;
		logic       any_byte_seen;
	} scan_state_t;

	function automatic verdict_t verdict_of(input logic failed, input logic unfinished,
			input logic high_seen);
		verdict_t v;
		if (failed || unfinished) begin
			v = VERDICT_INVALID;
		end else if (high_seen) begin
			v = VERDICT_VALID;
		end else begin
			v = VERDICT_ASCII;
		end
		return v;
	endfunction

endpackage

// File: rtl/text_encoding_classifier_unit.sv
// ----------------------------------------------------------------------------
// Text encoding classifier unit
// Byte-serial UTF-8 / GBK / Shift-JIS validation with a per-string verdict.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one string byte per transaction: tdata holds the
//   byte, tuser says whether the byte is real, tlast marks the final
//   transaction of a string (tuser low with tlast high on its own is the
//   empty string or ends a string without a byte). Idle transactions with
//   tuser and tlast both low change nothing.
//   The master channel carries one result per string, taken from the final
//   transaction: class and the three validator verdicts.
//   The result is registered: the final transaction passes the input
//   register, then the result register. Throughput: one transaction per
//   cycle unless a string end is held in the input register; the per-byte
//   validator update is a few byte compares feeding the state registers.
//   Reset clears all validator state and both registers' valid flags.
//   When the receiver stalls, the result register holds; byte transactions
//   keep flowing, and a string end waits in the input register until the
//   result register is free.
// ----------------------------------------------------------------------------
module text_encoding_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // end_flag
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [2:0] string_class, [4:3] utf8_verdict,
	                                    // [6:5] gbk_verdict, [8:7] sjis_verdict
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 has_s1;
	logic                 last_s1;

	logic                 res_valid_s2;
	tec_pkg::class_t      class_s2;
	tec_pkg::verdict_t    utf8_v_s2;
	tec_pkg::verdict_t    gbk_v_s2;
	tec_pkg::verdict_t    sjis_v_s2;

	tec_pkg::scan_state_t state_q;
	tec_pkg::scan_state_t scan_d;
	tec_pkg::scan_state_t state_d;

	tec_pkg::verdict_t    utf8_v;
	tec_pkg::verdict_t    gbk_v;
	tec_pkg::verdict_t    sjis_v;
	tec_pkg::class_t      class_d;

	logic                 advance;
	logic                 load_result;
	logic                 s_accept;

	assign advance       = !last_s1 || !res_valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign load_result   = valid_s1 && last_s1 && advance;

	always_comb begin
		logic [7:0] b;
		b      = byte_s1;
		scan_d = state_q;
		if (has_s1) begin
			scan_d.any_byte_seen = 1'b1;
			if (b >= tec_pkg::BYTE_HIGH) begin
				scan_d.high_seen = 1'b1;
			end

			if (!state_q.utf8_failed) begin
				if (state_q.utf8_remaining != 3'd0) begin
					if (b[7:6] != 2'b10) begin
						scan_d.utf8_failed = 1'b1;
					end else begin
						scan_d.utf8_remaining = state_q.utf8_remaining - 3'd1;
					end
				end else if (b >= tec_pkg::BYTE_HIGH) begin
					priority if (b >= tec_pkg::UTF8_LEAD_BAD) begin
						scan_d.utf8_failed = 1'b1;
					end else if (b >= tec_pkg::UTF8_LEAD_6) begin
						scan_d.utf8_remaining = 3'd5;
					end else if (b >= tec_pkg::UTF8_LEAD_5) begin
						scan_d.utf8_remaining = 3'd4;
					end else if (b >= tec_pkg::UTF8_LEAD_4) begin
						scan_d.utf8_remaining = 3'd3;
					end else if (b >= tec_pkg::UTF8_LEAD_3) begin
						scan_d.utf8_remaining = 3'd2;
					end else if (b >= tec_pkg::UTF8_LEAD_2) begin
						scan_d.utf8_remaining = 3'd1;
					end else begin
						scan_d.utf8_failed = 1'b1;
					end
				end
			end

			if (!state_q.gbk_failed) begin
				if (state_q.gbk_pending) begin
					if (b < tec_pkg::TRAIL_LO || b > tec_pkg::GBK_TRAIL_HI) begin
						scan_d.gbk_failed = 1'b1;
					end else begin
						scan_d.gbk_pending = 1'b0;
					end
				end else if (b >= tec_pkg::BYTE_HIGH) begin
					if (b >= tec_pkg::MB_LEAD_LO && b <= tec_pkg::GBK_LEAD_HI) begin
						scan_d.gbk_pending = 1'b1;
					end else begin
						scan_d.gbk_failed = 1'b1;
					end
				end
			end

			if (!state_q.sjis_failed) begin
				if (state_q.sjis_pending) begin
					if (b < tec_pkg::TRAIL_LO || b > tec_pkg::SJIS_TRAIL_HI ||
							b == tec_pkg::SJIS_TRAIL_BAD) begin
						scan_d.sjis_failed = 1'b1;
					end else begin
						scan_d.sjis_pending = 1'b0;
					end
				end else if (b >= tec_pkg::BYTE_HIGH) begin
					priority if (b >= tec_pkg::SJIS_KANA_LO && b <= tec_pkg::SJIS_KANA_HI) begin
						scan_d.sjis_pending = 1'b0;
					end else if ((b >= tec_pkg::MB_LEAD_LO && b <= tec_pkg::SJIS_LEAD1_HI) ||
							(b >= tec_pkg::SJIS_LEAD2_LO && b <= tec_pkg::SJIS_LEAD2_HI)) begin
						scan_d.sjis_pending = 1'b1;
					end else begin
						scan_d.sjis_failed = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		utf8_v = tec_pkg::verdict_of(scan_d.utf8_failed, scan_d.utf8_remaining != 3'd0,
			scan_d.high_seen);
		gbk_v  = tec_pkg::verdict_of(scan_d.gbk_failed, scan_d.gbk_pending, scan_d.high_seen);
		sjis_v = tec_pkg::verdict_of(scan_d.sjis_failed, scan_d.sjis_pending,
			scan_d.high_seen);
		if (!scan_d.any_byte_seen) begin
			utf8_v  = tec_pkg::VERDICT_INVALID;
			gbk_v   = tec_pkg::VERDICT_INVALID;
			sjis_v  = tec_pkg::VERDICT_INVALID;
			class_d = tec_pkg::CLASS_EMPTY;
		end else begin
			priority if (utf8_v == tec_pkg::VERDICT_VALID) begin
				class_d = tec_pkg::CLASS_UTF8;
			end else if (utf8_v == tec_pkg::VERDICT_ASCII) begin
				class_d = tec_pkg::CLASS_ASCII;
			end else if (gbk_v == tec_pkg::VERDICT_VALID) begin
				class_d = tec_pkg::CLASS_GBK;
			end else if (gbk_v == tec_pkg::VERDICT_ASCII) begin
				class_d = tec_pkg::CLASS_ASCII;
			end else if (sjis_v == tec_pkg::VERDICT_VALID) begin
				class_d = tec_pkg::CLASS_SJIS;
			end else if (sjis_v == tec_pkg::VERDICT_ASCII) begin
				class_d = tec_pkg::CLASS_ASCII;
			end else begin
				class_d = tec_pkg::CLASS_OTHER;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		if (valid_s1 && advance) begin
			state_d = last_s1 ? '0 : scan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			state_q      <= '0;
		end else begin
			state_q <= state_d;
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (load_result) begin
				res_valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
		if (load_result) begin
			class_s2  <= class_d;
			utf8_v_s2 <= utf8_v;
			gbk_v_s2  <= gbk_v;
			sjis_v_s2 <= sjis_v;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = {7'd0, sjis_v_s2, gbk_v_s2, utf8_v_s2, class_s2};

	a_remaining_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.utf8_remaining <= 3'd5)
		else $error("utf8 continuation count out of range");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> (state_q == '0))
		else $error("scan state not cleared after string end");

	a_empty_verdicts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && class_s2 == tec_pkg::CLASS_EMPTY) |->
		(utf8_v_s2 == tec_pkg::VERDICT_INVALID && gbk_v_s2 == tec_pkg::VERDICT_INVALID &&
		sjis_v_s2 == tec_pkg::VERDICT_INVALID))
		else $error("empty string with nonzero verdict");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && last_s1 && res_valid_s2 && !m_axis_tready))
		else $error("input stalled without a pending result");

endmodule

// File: tb/tec_result_checker.sv
// ----------------------------------------------------------------------------
// Text encoding classifier result checker
// Watches both stream channels of the classifier. Every accepted byte
// transaction updates an independent copy of the UTF-8, GBK and Shift-JIS
// validators; a string end queues the expected class and verdicts. Each
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module tec_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] has_byte
	input  logic        s_axis_tlast,   // end_flag
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [2:0] string_class, [4:3] utf8_verdict,
	                                    // [6:5] gbk_verdict, [8:7] sjis_verdict
	output int          mismatches,
	output int          outstanding
);

	typedef struct {
		tec_pkg::class_t   cls;
		tec_pkg::verdict_t utf8;
		tec_pkg::verdict_t gbk;
		tec_pkg::verdict_t sjis;
	} string_result_t;

	logic [2:0] utf8_left;
	logic       utf8_bad;
	logic       gbk_wait;
	logic       gbk_bad;
	logic       sjis_wait;
	logic       sjis_bad;
	logic       high_byte_seen;
	logic       byte_seen;

	string_result_t expected_results[$];
	int             error_count = 0;

	assign mismatches = error_count;

	task automatic clear_scan();
		utf8_left      = 3'd0;
		utf8_bad       = 1'b0;
		gbk_wait       = 1'b0;
		gbk_bad        = 1'b0;
		sjis_wait      = 1'b0;
		sjis_bad       = 1'b0;
		high_byte_seen = 1'b0;
		byte_seen      = 1'b0;
	endtask

	function automatic tec_pkg::verdict_t judge(input logic bad, input logic unfinished,
			input logic hi);
		tec_pkg::verdict_t v;
		if (bad || unfinished) begin
			v = tec_pkg::VERDICT_INVALID;
		end else if (hi) begin
			v = tec_pkg::VERDICT_VALID;
		end else begin
			v = tec_pkg::VERDICT_ASCII;
		end
		return v;
	endfunction

	task automatic scan_transaction(input logic [7:0] b, input logic has, input logic last);
		string_result_t r;
		if (has) begin
			byte_seen = 1'b1;
			if (b >= tec_pkg::BYTE_HIGH) begin
				high_byte_seen = 1'b1;
			end
			if (!utf8_bad) begin
				if (utf8_left != 3'd0) begin
					if (b[7:6] != 2'b10) begin
						utf8_bad = 1'b1;
					end else begin
						utf8_left = utf8_left - 3'd1;
					end
				end else if (b >= tec_pkg::BYTE_HIGH) begin
					if (b >= tec_pkg::UTF8_LEAD_BAD) begin
						utf8_bad = 1'b1;
					end else if (b >= tec_pkg::UTF8_LEAD_6) begin
						utf8_left = 3'd5;
					end else if (b >= tec_pkg::UTF8_LEAD_5) begin
						utf8_left = 3'd4;
					end else if (b >= tec_pkg::UTF8_LEAD_4) begin
						utf8_left = 3'd3;
					end else if (b >= tec_pkg::UTF8_LEAD_3) begin
						utf8_left = 3'd2;
					end else if (b >= tec_pkg::UTF8_LEAD_2) begin
						utf8_left = 3'd1;
					end else begin
						utf8_bad = 1'b1;
					end
				end
			end
			if (!gbk_bad) begin
				if (gbk_wait) begin
					if (b < tec_pkg::TRAIL_LO || b > tec_pkg::GBK_TRAIL_HI) begin
						gbk_bad = 1'b1;
					end else begin
						gbk_wait = 1'b0;
					end
				end else if (b >= tec_pkg::BYTE_HIGH) begin
					if (b >= tec_pkg::MB_LEAD_LO && b <= tec_pkg::GBK_LEAD_HI) begin
						gbk_wait = 1'b1;
					end else begin
						gbk_bad = 1'b1;
					end
				end
			end
			if (!sjis_bad) begin
				if (sjis_wait) begin
					if (b < tec_pkg::TRAIL_LO || b > tec_pkg::SJIS_TRAIL_HI ||
							b == tec_pkg::SJIS_TRAIL_BAD) begin
						sjis_bad = 1'b1;
					end else begin
						sjis_wait = 1'b0;
					end
				end else if (b >= tec_pkg::BYTE_HIGH &&
						!(b >= tec_pkg::SJIS_KANA_LO && b <= tec_pkg::SJIS_KANA_HI)) begin
					if ((b >= tec_pkg::MB_LEAD_LO && b <= tec_pkg::SJIS_LEAD1_HI) ||
							(b >= tec_pkg::SJIS_LEAD2_LO && b <= tec_pkg::SJIS_LEAD2_HI)) begin
						sjis_wait = 1'b1;
					end else begin
						sjis_bad = 1'b1;
					end
				end
			end
		end
		if (last) begin
			if (!byte_seen) begin
				r.cls  = tec_pkg::CLASS_EMPTY;
				r.utf8 = tec_pkg::VERDICT_INVALID;
				r.gbk  = tec_pkg::VERDICT_INVALID;
				r.sjis = tec_pkg::VERDICT_INVALID;
			end else begin
				r.utf8 = judge(utf8_bad, utf8_left != 3'd0, high_byte_seen);
				r.gbk  = judge(gbk_bad, gbk_wait, high_byte_seen);
				r.sjis = judge(sjis_bad, sjis_wait, high_byte_seen);
				if (r.utf8 == tec_pkg::VERDICT_VALID) begin
					r.cls = tec_pkg::CLASS_UTF8;
				end else if (r.utf8 == tec_pkg::VERDICT_ASCII) begin
					r.cls = tec_pkg::CLASS_ASCII;
				end else if (r.gbk == tec_pkg::VERDICT_VALID) begin
					r.cls = tec_pkg::CLASS_GBK;
				end else if (r.gbk == tec_pkg::VERDICT_ASCII) begin
					r.cls = tec_pkg::CLASS_ASCII;
				end else if (r.sjis == tec_pkg::VERDICT_VALID) begin
					r.cls = tec_pkg::CLASS_SJIS;
				end else if (r.sjis == tec_pkg::VERDICT_ASCII) begin
					r.cls = tec_pkg::CLASS_ASCII;
				end else begin
					r.cls = tec_pkg::CLASS_OTHER;
				end
			end
			expected_results.push_back(r);
			clear_scan();
		end
	endtask

	task automatic check_result(input logic [15:0] d);
		string_result_t e;
		if (expected_results.size() == 0) begin
			$error("result transaction with no string pending: tdata %h", d);
			error_count++;
		end else begin
			e = expected_results.pop_front();
			if (d[2:0] !== e.cls) begin
				$error("string_class: expected %0d, actual %0d", e.cls, d[2:0]);
				error_count++;
			end
			if (d[4:3] !== e.utf8) begin
				$error("utf8_verdict: expected %0d, actual %0d", e.utf8, d[4:3]);
				error_count++;
			end
			if (d[6:5] !== e.gbk) begin
				$error("gbk_verdict: expected %0d, actual %0d", e.gbk, d[6:5]);
				error_count++;
			end
			if (d[8:7] !== e.sjis) begin
				$error("sjis_verdict: expected %0d, actual %0d", e.sjis, d[8:7]);
				error_count++;
			end
			if (d[15:9] !== 7'd0) begin
				$error("tdata padding: expected 0, actual %h", d[15:9]);
				error_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				scan_transaction(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tdata);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Text encoding classifier testbench
// Sends directed strings covering the lead and trail byte limits of each
// encoding, empty strings, idle transactions and ends without a byte, then
// random strings built mostly from well-formed UTF-8, GBK and Shift-JIS
// characters with some corrupted or truncated, under random stalls on both
// channels. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS   = 900;
	localparam int IDLE_PCT       = 14;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 10;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tuser  = 1'b0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	int         mismatches;
	int         outstanding;
	int         item_count      = 0;
	int         watchdog_cycles = 0;
	bit         steady          = 1'b0;
	logic [7:0] text_q[$];

	text_encoding_classifier_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tec_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin
		while (watchdog_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				watchdog_cycles = 0;
			end else begin
				watchdog_cycles++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_transaction(input logic [7:0] b, input logic has, input logic last);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= has;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (has || last) begin
			item_count++;
		end
	endtask

	task automatic send_string(input bit split_end, input bit noisy);
		int n;
		n = text_q.size();
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 99) < 5) begin
				send_transaction(8'($urandom), 1'b0, 1'b0);
			end
			send_transaction(text_q[i], 1'b1, !split_end && i == n - 1);
		end
		if (split_end || n == 0) begin
			send_transaction(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic push_range(input int lo, input int hi);
		text_q.push_back(8'($urandom_range(lo, hi)));
	endtask

	task automatic push_sjis_trail();
		logic [7:0] b;
		b = 8'($urandom_range(8'h40, 8'hFC));
		if (b == 8'h7F) begin
			b = 8'h80;
		end
		text_q.push_back(b);
	endtask

	task automatic make_text();
		int kind;
		int chars;
		int pick;
		int follow;
		text_q.delete();
		kind  = $urandom_range(0, 99);
		chars = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
		repeat (chars) begin
			pick = $urandom_range(0, 9);
			if (kind < 30) begin
				follow = 0;
				if (pick <= 3) begin
					push_range(8'h00, 8'h7F);
				end else if (pick <= 6) begin
					push_range(8'hC0, 8'hDF);
					follow = 1;
				end else if (pick == 7) begin
					push_range(8'hE0, 8'hEF);
					follow = 2;
				end else if (pick == 8) begin
					push_range(8'hF0, 8'hF7);
					follow = 3;
				end else if ($urandom_range(0, 1) == 0) begin
					push_range(8'hF8, 8'hFB);
					follow = 4;
				end else begin
					push_range(8'hFC, 8'hFD);
					follow = 5;
				end
				repeat (follow) push_range(8'h80, 8'hBF);
			end else if (kind < 55) begin
				if (pick <= 2) begin
					push_range(8'h00, 8'h7F);
				end else begin
					push_range(8'h81, 8'hFE);
					push_range(8'h40, 8'hFE);
				end
			end else if (kind < 80) begin
				if (pick <= 2) begin
					push_range(8'h00, 8'h7F);
				end else if (pick <= 4) begin
					push_range(8'hA1, 8'hDF);
				end else if (pick <= 7) begin
					push_range(8'h81, 8'h9F);
					push_sjis_trail();
				end else begin
					push_range(8'hE0, 8'hEF);
					push_sjis_trail();
				end
			end else if (kind < 90) begin
				push_range(8'h00, 8'h7F);
			end else begin
				push_range(8'h00, 8'hFF);
			end
		end
		if (text_q.size() > 0 && $urandom_range(0, 9) == 0) begin
			text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
		end
		if (text_q.size() > 0 && $urandom_range(0, 9) == 0) begin
			void'(text_q.pop_back());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string, an idle transaction, then ASCII with a zero byte and a bare end
		text_q = {};
		send_string(1'b0, 1'b0);
		send_transaction(8'h55, 1'b0, 1'b0);
		text_q = '{8'h00, 8'h7F};
		send_string(1'b1, 1'b0);
		text_q = '{8'hE0, 8'hA0, 8'h80};
		send_string(1'b0, 1'b0);
		text_q = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'hBF};
		send_string(1'b0, 1'b0);
		text_q = '{8'hFE};
		send_string(1'b0, 1'b0);
		text_q = '{8'h81, 8'h40, 8'hFE, 8'hFE};
		send_string(1'b0, 1'b0);
		text_q = '{8'h9F, 8'h40, 8'hA1};
		send_string(1'b0, 1'b0);
		text_q = '{8'hFF};
		send_string(1'b0, 1'b0);
		text_q = '{8'hC0};
		send_string(1'b1, 1'b0);

		item_count = 0;
		while (item_count < RANDOM_ITEMS) begin
			steady = (item_count >= 300 && item_count < 450);
			make_text();
			send_string($urandom_range(0, 4) == 0, 1'b1);
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
